// ----- src/pnorm_pkg.sv -----
// Shared types, character codes and queue sizing for the path normaliser.
package pnorm_pkg;

    localparam logic [7:0] CH_END       = 8'h00;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    localparam int Q_DEPTH_DEFAULT = 4;

    typedef enum logic [3:0] {
        PH_START   = 4'b0001,
        PH_ONEDOT  = 4'b0010,
        PH_TWODOTS = 4'b0100,
        PH_OTHER   = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DOTDOT    = 2'd1,
        ST_BACKSLASH = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // Work for the back end: an optional slash, up to three dots, an optional
    // byte, or a closing status word.
    typedef struct packed {
        logic       sep;
        logic [1:0] ndots;
        logic       has_ch;
        logic [7:0] ch;
        logic       done;
        t_status    status;
    } t_cmd;

endpackage

// ----- src/pnorm_front.sv -----
// Front end: accepts path bytes, tracks the component state and issues commands.
module pnorm_front
    import pnorm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_phase  r_phase, n_phase;
    logic    r_sep_owed, n_sep_owed;
    logic    r_emitted, n_emitted;
    t_status r_err, n_err;
    t_cmd    n_cmd;
    logic    accept;
    logic    is_end;
    logic    is_slash;

    assign o_ready  = !i_full;
    assign accept   = i_valid && o_ready;
    assign is_end   = (i_data == CH_END);
    assign is_slash = (i_data == CH_SLASH);

    always_comb begin
        n_phase    = r_phase;
        n_sep_owed = r_sep_owed;
        n_emitted  = r_emitted;
        n_err      = r_err;
        n_cmd      = '0;
        n_cmd.status = ST_OK;
        if (is_end || is_slash) begin
            if (r_err == ST_OK) begin
                if (r_phase == PH_TWODOTS) begin
                    n_err = ST_DOTDOT;
                end else if (r_phase == PH_OTHER && is_slash) begin
                    n_sep_owed = 1'b1;
                end
                n_phase = PH_START;
            end
            if (is_end) begin
                n_cmd.done = 1'b1;
                if (n_err != ST_OK) begin
                    n_cmd.status = n_err;
                end else if (!r_emitted) begin
                    n_cmd.status = ST_EMPTY;
                end else begin
                    n_cmd.status = ST_OK;
                end
                n_phase    = PH_START;
                n_sep_owed = 1'b0;
                n_err      = ST_OK;
            end
        end else if (r_err != ST_OK) begin
            n_phase = r_phase;
        end else if (i_data == CH_BACKSLASH) begin
            n_err = ST_BACKSLASH;
        end else if (i_data == CH_DOT) begin
            unique case (r_phase)
                PH_START: begin
                    n_phase = PH_ONEDOT;
                end
                PH_ONEDOT: begin
                    n_phase = PH_TWODOTS;
                end
                PH_TWODOTS: begin
                    n_cmd.sep   = r_sep_owed;
                    n_cmd.ndots = 2'd3;
                    n_sep_owed  = 1'b0;
                    n_phase     = PH_OTHER;
                end
                PH_OTHER: begin
                    n_cmd.has_ch = 1'b1;
                    n_cmd.ch     = CH_DOT;
                end
                default: begin
                    n_phase = PH_START;
                end
            endcase
        end else begin
            if (r_phase != PH_OTHER) begin
                n_cmd.sep  = r_sep_owed;
                n_sep_owed = 1'b0;
                if (r_phase == PH_ONEDOT) begin
                    n_cmd.ndots = 2'd1;
                end else if (r_phase == PH_TWODOTS) begin
                    n_cmd.ndots = 2'd2;
                end
            end
            n_cmd.has_ch = 1'b1;
            n_cmd.ch     = i_data;
            n_phase      = PH_OTHER;
        end
        if (!is_end) begin
            n_emitted = r_emitted | n_cmd.sep | (n_cmd.ndots != 2'd0) | n_cmd.has_ch;
        end else begin
            n_emitted = 1'b0;
        end
    end

    assign o_push = accept && (n_cmd.done || n_cmd.sep || (n_cmd.ndots != 2'd0)
                               || n_cmd.has_ch);
    assign o_cmd  = n_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_sep_owed <= 1'b0;
            r_emitted  <= 1'b0;
            r_err      <= ST_OK;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_sep_owed <= n_sep_owed;
            r_emitted  <= n_emitted;
            r_err      <= n_err;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_end) |=> (r_phase == PH_START && !r_sep_owed && !r_emitted
                                && r_err == ST_OK))
        else $error("State not cleared after the terminator word.");

    a_swallow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_err != ST_OK && !is_end) |-> !o_push)
        else $error("A word after an error produced output.");

    a_three_dots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && n_cmd.ndots == 2'd3) |-> (!n_cmd.has_ch && !n_cmd.done))
        else $error("Three released dots combined with another byte.");

endmodule

// ----- src/pnorm_fifo.sv -----
// Short command queue between the front end and the back end.
module pnorm_fifo
    import pnorm_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CW'(i_push && !o_full) - CW'(i_pop && !o_empty);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("Command pushed into a full queue.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("Command popped from an empty queue.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("Queue fill count beyond its depth.");

endmodule

// ----- src/pnorm_back.sv -----
// Back end: expands queued commands into output words, one per cycle while the receiver is ready.
module pnorm_back
    import pnorm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_char,
    output logic       o_has_char,
    output logic       o_done,
    output t_status    o_status,
    output logic       o_last
);

    t_cmd       r_cur;
    logic       r_cur_v;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_has;
    logic       r_out_done;
    t_status    r_out_status;
    logic       r_out_last;

    t_cmd       head;
    t_cmd       rest;
    logic       have_head;
    logic       can_load;
    logic [7:0] e_char;
    logic       e_has;
    logic       e_done;
    t_status    e_status;
    logic       e_last;

    assign can_load  = !r_out_valid || i_ready;
    assign have_head = r_cur_v || !i_empty;
    assign head      = r_cur_v ? r_cur : i_head;
    assign o_pop     = can_load && !r_cur_v && !i_empty;

    always_comb begin
        rest     = head;
        e_char   = '0;
        e_has    = 1'b1;
        e_done   = 1'b0;
        e_status = ST_OK;
        if (head.sep) begin
            e_char   = CH_SLASH;
            rest.sep = 1'b0;
        end else if (head.ndots != 2'd0) begin
            e_char     = CH_DOT;
            rest.ndots = head.ndots - 2'd1;
        end else if (head.has_ch) begin
            e_char      = head.ch;
            rest.has_ch = 1'b0;
        end else begin
            e_has     = 1'b0;
            e_done    = 1'b1;
            e_status  = head.status;
            rest.done = 1'b0;
        end
        e_last = !(rest.sep || (rest.ndots != 2'd0) || rest.has_ch || rest.done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (can_load) begin
            r_out_valid <= have_head;
            if (have_head) begin
                r_cur_v <= !e_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load && have_head) begin
            r_cur        <= rest;
            r_out_char   <= e_char;
            r_out_has    <= e_has;
            r_out_done   <= e_done;
            r_out_status <= e_status;
            r_out_last   <= e_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_char     = r_out_char;
    assign o_has_char = r_out_has;
    assign o_done     = r_out_done;
    assign o_status   = r_out_status;
    assign o_last     = r_out_last;

endmodule

// ----- src/path_normalizer_core.sv -----
// Top level of the streaming path normaliser.
//
// Paths arrive on the slave stream one byte per word in tdata; a zero byte
// ends a path. Normalised bytes leave on the master stream: tdata carries
// the byte, tuser says what the word is and tlast marks the last word caused
// by one input byte. A status word (tuser has_char low, path_done high)
// closes every path with ok, dotdot, backslash or empty; on a nonzero status
// the receiver discards the bytes already delivered for that path.
// An input byte is taken in every cycle while the command queue has room;
// it yields zero to four output words. With the back end idle, the command is
// queued and the first word is registered at the output; words then follow at
// one per cycle while the receiver is ready. Sustained throughput is one input
// byte per cycle as long as the output averages about one word per byte; the
// back end, which delivers one word a cycle, sets the limit, and the queue of
// QUEUE_DEPTH commands absorbs the bursts. When the receiver stalls, the output
// word holds, the queue fills and tready then drops. Reset clears the path
// state, empties the queue and drops tvalid on the master side.
module path_normalizer_core
    import pnorm_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] ch
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_char
    output logic [3:0] o_m_axis_tuser,   // [0] has_char, [1] path_done, [3:2] status
    output logic       o_m_axis_tlast    // run_last
);

    logic    push;
    t_cmd    push_cmd;
    logic    q_full;
    logic    q_empty;
    logic    pop;
    t_cmd    q_head;
    logic    out_has;
    logic    out_done;
    t_status out_status;

    pnorm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    pnorm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    pnorm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_head     (q_head),
        .o_pop      (pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_char     (o_m_axis_tdata),
        .o_has_char (out_has),
        .o_done     (out_done),
        .o_status   (out_status),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = {out_status, out_done, out_has};

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the streaming path normaliser core.
module tb;
    import pnorm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_ch;
        logic       done;
        t_status    status;
        logic       last;
    } t_out_word;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [3:0] m_tuser;
    logic       m_tlast;
    logic       hold_off = 1'b0;

    logic [7:0] pending_bytes[$];
    t_out_word  expected_words[$];
    t_out_word  burst[$];

    int total_bytes = 0;
    int bytes_taken = 0;
    int words_seen = 0;
    int mismatches = 0;
    int paths_by_status[4] = '{0, 0, 0, 0};

    t_phase  phase = PH_START;
    logic    sep_owed = 1'b0;
    logic    emitted_any = 1'b0;
    t_status path_err = ST_OK;

    path_normalizer_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void put_word(logic [7:0] c, logic has, logic done, t_status st);
        burst.push_back('{ch: c, has_ch: has, done: done, status: st, last: 1'b0});
        if (has) begin
            emitted_any = 1'b1;
        end
    endfunction

    // A kept component starts: pay any owed slash, then release the held dots.
    function automatic void open_component(int held_dots);
        if (sep_owed) begin
            put_word(CH_SLASH, 1'b1, 1'b0, ST_OK);
            sep_owed = 1'b0;
        end
        repeat (held_dots) put_word(CH_DOT, 1'b1, 1'b0, ST_OK);
    endfunction

    function automatic void normalise_byte(logic [7:0] c);
        t_status st;
        burst.delete();
        if (c == CH_END || c == CH_SLASH) begin
            if (path_err == ST_OK) begin
                if (phase == PH_TWODOTS) begin
                    path_err = ST_DOTDOT;
                end else if (phase == PH_OTHER && c == CH_SLASH) begin
                    sep_owed = 1'b1;
                end
                phase = PH_START;
            end
            if (c == CH_END) begin
                st = (path_err != ST_OK) ? path_err : (emitted_any ? ST_OK : ST_EMPTY);
                put_word(8'h00, 1'b0, 1'b1, st);
                paths_by_status[st]++;
                phase = PH_START;
                sep_owed = 1'b0;
                emitted_any = 1'b0;
                path_err = ST_OK;
            end
        end else if (path_err != ST_OK) begin
            // Swallowed until the terminator.
        end else if (c == CH_BACKSLASH) begin
            path_err = ST_BACKSLASH;
        end else if (c == CH_DOT) begin
            case (phase)
                PH_START: phase = PH_ONEDOT;
                PH_ONEDOT: phase = PH_TWODOTS;
                PH_TWODOTS: begin
                    open_component(3);
                    phase = PH_OTHER;
                end
                default: put_word(CH_DOT, 1'b1, 1'b0, ST_OK);
            endcase
        end else begin
            case (phase)
                PH_START: open_component(0);
                PH_ONEDOT: open_component(1);
                PH_TWODOTS: open_component(2);
                default: ;
            endcase
            put_word(c, 1'b1, 1'b0, ST_OK);
            phase = PH_OTHER;
        end
        if (burst.size() > 0) begin
            burst[burst.size() - 1].last = 1'b1;
            foreach (burst[i]) expected_words.push_back(burst[i]);
        end
    endfunction

    function automatic int idle_share(bit receiver);
        if (bytes_taken * 3 < total_bytes) begin
            return receiver ? 52 : 21;
        end
        if (bytes_taken * 3 < total_bytes * 2) begin
            return receiver ? 21 : 52;
        end
        return 0;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while (b == CH_SLASH || b == CH_DOT || b == CH_BACKSLASH);
        return b;
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                normalise_byte(s_tdata);
                bytes_taken++;
                void'(pending_bytes.pop_front());
            end
            if (pending_bytes.size() > 0 && $urandom_range(99) >= idle_share(1'b0)) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_bytes[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        t_out_word want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    report_mismatch("word with nothing expected", m_tdata, 8'h00);
                end else begin
                    want = expected_words.pop_front();
                    if (m_tdata !== want.ch)
                        report_mismatch("out_char", m_tdata, want.ch);
                    if (m_tuser[0] !== want.has_ch)
                        report_mismatch("has_char", 8'(m_tuser[0]), 8'(want.has_ch));
                    if (m_tuser[1] !== want.done)
                        report_mismatch("path_done", 8'(m_tuser[1]), 8'(want.done));
                    if (m_tuser[3:2] !== want.status)
                        report_mismatch("status", 8'(m_tuser[3:2]), 8'(want.status));
                    if (m_tlast !== want.last)
                        report_mismatch("run_last", 8'(m_tlast), 8'(want.last));
                end
            end
            m_tready <= !hold_off && ($urandom_range(99) >= idle_share(1'b1));
        end
    end

    // Long receiver stall while the sender keeps offering, so the queue fills.
    initial begin
        do @(posedge clk); while (total_bytes == 0 || bytes_taken < (total_bytes * 2) / 3 + 20);
        hold_off <= 1'b1;
        repeat (150) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d words still expected.", expected_words.size());
        $display("** path_normalizer_core: FAILED **");
        $finish;
    end

    initial begin
        int comps;
        int kind;
        pending_bytes.push_back(CH_END);
        push_text("../");
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(CH_END);
        push_text("a\\b");
        pending_bytes.push_back(CH_END);
        push_text("/./..y//.x/...");
        pending_bytes.push_back(CH_END);

        while (pending_bytes.size() < 230) begin
            if ($urandom_range(7) == 0) begin
                repeat ($urandom_range(1, 8)) pending_bytes.push_back(8'($urandom_range(1, 255)));
            end else begin
                comps = $urandom_range(1, 4);
                for (int i = 0; i < comps; i++) begin
                    if (i > 0 || $urandom_range(1) == 1)
                        pending_bytes.push_back(CH_SLASH);
                    kind = $urandom_range(0, 19);
                    case (kind)
                        10: ;
                        11: pending_bytes.push_back(CH_DOT);
                        12: repeat (2) pending_bytes.push_back(CH_DOT);
                        13: repeat ($urandom_range(3, 5)) pending_bytes.push_back(CH_DOT);
                        14: begin
                            pending_bytes.push_back(CH_DOT);
                            pending_bytes.push_back(plain_byte());
                        end
                        15: begin
                            repeat (2) pending_bytes.push_back(CH_DOT);
                            pending_bytes.push_back(plain_byte());
                        end
                        16: begin
                            pending_bytes.push_back(plain_byte());
                            pending_bytes.push_back(CH_DOT);
                            pending_bytes.push_back(plain_byte());
                        end
                        17: begin
                            pending_bytes.push_back(plain_byte());
                            if ($urandom_range(2) == 0)
                                pending_bytes.push_back(CH_BACKSLASH);
                            pending_bytes.push_back(plain_byte());
                        end
                        default: repeat ($urandom_range(1, 4)) pending_bytes.push_back(plain_byte());
                    endcase
                end
                if ($urandom_range(2) == 0)
                    pending_bytes.push_back(CH_SLASH);
            end
            pending_bytes.push_back(CH_END);
        end
        total_bytes = pending_bytes.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        do @(posedge clk); while (pending_bytes.size() > 0 || s_tvalid);
        while (expected_words.size() > 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run covered %0d input bytes and %0d output words, with a long receiver stall.",
                 bytes_taken, words_seen);
        $display("Paths closed: %0d ok, %0d dotdot, %0d backslash, %0d empty.",
                 paths_by_status[ST_OK], paths_by_status[ST_DOTDOT],
                 paths_by_status[ST_BACKSLASH], paths_by_status[ST_EMPTY]);
        if (mismatches == 0) begin
            $display("** path_normalizer_core: PASSED **");
        end else begin
            $display("** path_normalizer_core: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/pnorm_pkg.sv
src/pnorm_front.sv
src/pnorm_fifo.sv
src/pnorm_back.sv
src/path_normalizer_core.sv
tb/sv/tb.sv
